>>> src/trnenc_pkg.sv
package trnenc_pkg;

    // Lane count used when the top level is not overridden.
    localparam int LANES_DEF = 8;

    // Field widths.
    localparam int FREQ_W  = 14;
    localparam int CUM_W   = 15;
    localparam int STATE_W = 31;
    localparam int LANE_W  = 3;
    localparam int SYM_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 2;

    // Probability scale and renormalization threshold exponent.
    // The threshold is ((2^23 >> 14) << 8) * f = f << 17.
    localparam int SCALE_BITS   = 14;
    localparam int RENORM_SHIFT = 17;

    // Radix-4 divider: quotient bits (rounded up to even) and iterations.
    localparam int QUO_W     = 18;
    localparam int DIV_STEPS = QUO_W / 2;

    // Bytes emitted by a flush, and the sequencer step counter width.
    localparam int FLUSH_BYTES = 4;
    localparam int CNT_W       = 4;

    // Queue depths.
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;

    // Reset values.
    localparam logic [FREQ_W-1:0]  FREQ0_RST = 14'd5462;
    localparam logic [FREQ_W-1:0]  FREQ1_RST = 14'd5461;
    localparam logic [FREQ_W-1:0]  FREQ2_RST = 14'd5461;
    localparam logic [STATE_W-1:0] STATE_RST = 31'd8388608;

    // Item commands.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_FREQ_ZERO = 2'd0;
    localparam logic [IDX_W-1:0] REG_FREQ_ONE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_FREQ_TWO  = 2'd2;

    // Symbol codes.
    localparam logic [SYM_W-1:0] SYM_ZERO = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ONE  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_TWO  = 2'd2;
    localparam logic [SYM_W-1:0] SYM_NONE = 2'd3;

    // Classified work handed from the front end to the coder.
    typedef struct packed {
        logic              flush;
        logic [LANE_W-1:0] lane;
        logic [FREQ_W-1:0] freq;
        logic [CUM_W-1:0]  cum;
    } t_cmd;

    // One emitted byte.
    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_res;

endpackage

>>> src/trnenc_fifo.sv
module trnenc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/trnenc_front.sv
module trnenc_front
    import trnenc_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [FREQ_W-1:0] i_cfg_data,
    input  logic              i_accept,
    input  logic              i_cmd,
    input  logic [LANE_W-1:0] i_lane,
    input  logic [SYM_W-1:0]  i_symbol,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd
);

    localparam logic [LANE_W+1:0] LANE_LIM = (LANE_W + 2)'(LANES);

    logic [FREQ_W-1:0] r_freq0;
    logic [FREQ_W-1:0] r_freq1;
    logic [FREQ_W-1:0] r_freq2;
    logic [FREQ_W-1:0] f0_eff;
    logic [FREQ_W-1:0] f1_eff;
    logic [FREQ_W-1:0] f2_eff;
    logic              lane_ok;
    logic              sym_ok;

    // A frequency register holding zero acts as one.
    function automatic logic [FREQ_W-1:0] eff_freq(input logic [FREQ_W-1:0] f);
        eff_freq = (f == '0) ? FREQ_W'(1) : f;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq0 <= FREQ0_RST;
            r_freq1 <= FREQ1_RST;
            r_freq2 <= FREQ2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FREQ_ZERO: r_freq0 <= i_cfg_data;
                REG_FREQ_ONE:  r_freq1 <= i_cfg_data;
                REG_FREQ_TWO:  r_freq2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign f0_eff = eff_freq(r_freq0);
    assign f1_eff = eff_freq(r_freq1);
    assign f2_eff = eff_freq(r_freq2);

    // Items on a lane that does not exist, and encodes of the unused symbol
    // code, are dropped here and never reach the coder.
    assign lane_ok     = ({2'b00, i_lane} < LANE_LIM);
    assign sym_ok      = (i_cmd == CMD_FLUSH) || (i_symbol != SYM_NONE);
    assign o_cmd_valid = i_accept && lane_ok && sym_ok;

    always_comb begin
        o_cmd.flush = (i_cmd == CMD_FLUSH);
        o_cmd.lane  = i_lane;
        case (i_symbol)
            SYM_ZERO: begin
                o_cmd.freq = f0_eff;
                o_cmd.cum  = '0;
            end
            SYM_ONE: begin
                o_cmd.freq = f1_eff;
                o_cmd.cum  = CUM_W'(f0_eff);
            end
            default: begin
                o_cmd.freq = f2_eff;
                o_cmd.cum  = CUM_W'(f0_eff) + CUM_W'(f1_eff);
            end
        endcase
    end

endmodule

>>> src/trnenc_back.sv
module trnenc_back
    import trnenc_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_avail,
    input  t_cmd i_cmd,
    output logic o_cmd_take,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    localparam int LIW = (LANES > 1) ? $clog2(LANES) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RENORM = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [STATE_W-1:0] r_st, n_st;
    t_cmd               r_cmd, n_cmd;
    logic [FREQ_W-1:0]  r_rem, n_rem;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [STATE_W-1:0] r_lanes [LANES];

    logic               lane_we;
    logic [STATE_W-1:0] lane_wdata;
    logic [LIW-1:0]     cur_idx;
    logic [STATE_W-1:0] st_shr;
    logic               need_renorm;
    logic               need_next;
    logic [FREQ_W+1:0]  rem4;
    logic [FREQ_W+1:0]  div_f1;
    logic [FREQ_W+1:0]  div_f2;
    logic [FREQ_W+1:0]  div_f3;
    logic [FREQ_W+1:0]  rem_next;
    logic [1:0]         digit;

    assign cur_idx = LIW'(r_cmd.lane);
    assign st_shr  = r_st >> BYTE_W;

    // State at or above freq << 17 needs another byte out.
    assign need_renorm = (r_st[STATE_W-1:RENORM_SHIFT] >= r_cmd.freq);
    assign need_next   = (st_shr[STATE_W-1:RENORM_SHIFT] >= r_cmd.freq);

    // One radix-4 restoring step: two dividend bits enter the partial remainder.
    assign rem4   = {r_rem, r_quo[QUO_W-1 -: 2]};
    assign div_f1 = (FREQ_W + 2)'(r_cmd.freq);
    assign div_f2 = div_f1 << 1;
    assign div_f3 = div_f1 + div_f2;

    always_comb begin
        if (rem4 >= div_f3) begin
            digit    = 2'd3;
            rem_next = rem4 - div_f3;
        end else if (rem4 >= div_f2) begin
            digit    = 2'd2;
            rem_next = rem4 - div_f2;
        end else if (rem4 >= div_f1) begin
            digit    = 2'd1;
            rem_next = rem4 - div_f1;
        end else begin
            digit    = 2'd0;
            rem_next = rem4;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_st       = r_st;
        n_cmd      = r_cmd;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        o_res.lane = r_cmd.lane;
        o_res.data = r_st[BYTE_W-1:0];
        o_res.last = 1'b0;
        lane_we    = 1'b0;
        lane_wdata = STATE_RST;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_avail) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    n_st       = r_lanes[LIW'(i_cmd.lane)];
                    n_cnt      = '0;
                    n_state    = i_cmd.flush ? S_FLUSH : S_RENORM;
                end
            end
            S_RENORM: begin
                if (need_renorm) begin
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        o_res.last = !need_next;
                        n_st       = st_shr;
                    end
                end else begin
                    // State is now below freq << 17, so its top 13 bits are
                    // below freq and the quotient fits in 17 bits.
                    n_rem   = FREQ_W'(r_st[STATE_W-1:QUO_W]);
                    n_quo   = r_st[QUO_W-1:0];
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = rem_next[FREQ_W-1:0];
                n_quo = {r_quo[QUO_W-3:0], digit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                lane_we    = 1'b1;
                lane_wdata = {r_quo[STATE_W-SCALE_BITS-1:0], {SCALE_BITS{1'b0}}}
                           + STATE_W'(r_rem) + STATE_W'(r_cmd.cum);
                n_state    = S_IDLE;
            end
            S_FLUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.last = (r_cnt == CNT_W'(FLUSH_BYTES - 1));
                    n_st       = st_shr;
                    n_cnt      = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(FLUSH_BYTES - 1)) begin
                        lane_we    = 1'b1;
                        lane_wdata = STATE_RST;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st  <= n_st;
        r_cmd <= n_cmd;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_lanes[i] <= STATE_RST;
            end
        end else if (lane_we) begin
            r_lanes[cur_idx] <= lane_wdata;
        end
    end

endmodule

>>> src/ternary_rans_encoder.sv
// Interleaved rANS encoder for ternary symbols with a 14-bit probability
// scale, 31-bit lane states and byte renormalization. Each input item either
// encodes one symbol on one lane or flushes a lane; the bytes it causes come
// out on the result side in emission order (last-in first-out per lane, so
// software reverses each lane's stream), with o_last marking the final byte
// of an item. An encode gives zero, one or two bytes, a flush always four.
// Items on a lane at or above LANES, and encodes of symbol code three, are
// dropped without any result. The coder works on one item at a time. An
// encode fetches the lane state, emits bytes while the state is at or above
// the threshold, finds the state below it and loads the divider, runs the
// radix-4 divider that forms state div freq and state mod freq, and writes
// the new state back. A flush fetches the lane state and emits four bytes.
// A two-entry command queue lets the input side run ahead of the coder, and
// a four-entry result queue keeps the coder going while the result side
// stalls; the coder waits only when that queue is full. The user must write
// the Frequency registers through i_cfg_we, i_cfg_idx and i_cfg_data only
// while the block is idle; the block itself does not enforce this. A
// register holding zero acts as one, and the three are expected to sum to
// 16384 (not checked). All lane states start at 2^23 after reset.
module ternary_rans_encoder
    import trnenc_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration writes.
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [FREQ_W-1:0] i_cfg_data,
    // Input queue side.
    input  logic              push,
    output logic              full,
    input  logic              i_cmd,
    input  logic [LANE_W-1:0] i_lane,
    input  logic [SYM_W-1:0]  i_symbol,
    // Result queue side.
    output logic              empty,
    input  logic              pop,
    output logic [LANE_W-1:0] o_out_lane,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last
);

    logic accept;
    logic cmd_valid;
    t_cmd front_cmd;
    t_cmd queued_cmd;
    logic cmdq_empty;
    logic cmd_take;
    logic res_push;
    logic res_full;
    t_res back_res;
    t_res head_res;

    // An input transfer happens whenever the command queue has room.
    assign accept = push && !full;

    // Front end: configuration registers and item classification. It turns
    // each valid item into a command with its frequency and cumulative
    // frequency already resolved.
    trnenc_front #(
        .LANES(LANES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_lane     (i_lane),
        .i_symbol   (i_symbol),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (front_cmd)
    );

    // Short queue between the front end and the coder. Its full flag is the
    // block's full flag, so a dropped item still waits for a free slot.
    trnenc_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_valid),
        .i_data (front_cmd),
        .o_full (full),
        .i_pop  (cmd_take),
        .o_data (queued_cmd),
        .o_empty(cmdq_empty)
    );

    // Coder: lane states, renormalization, divider and flush sequencing.
    trnenc_back #(
        .LANES(LANES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_avail(!cmdq_empty),
        .i_cmd      (queued_cmd),
        .o_cmd_take (cmd_take),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (back_res)
    );

    // Result queue; its head drives the result ports directly.
    trnenc_fifo #(
        .WIDTH($bits(t_res)),
        .DEPTH(OUTQ_DEPTH)
    ) u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (back_res),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (head_res),
        .o_empty(empty)
    );

    assign o_out_lane = head_res.lane;
    assign o_out_byte = head_res.data;
    assign o_last     = head_res.last;

endmodule

>>> src/trnenc_chk.sv
module trnenc_chk
    import trnenc_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [LANE_W-1:0] o_out_lane,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_last
);

    localparam logic [LANE_W+1:0] LANE_LIM = (LANE_W + 2)'(LANES);

    // The result queue comes out of reset empty and the command queue not full.
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> empty && !full)
        else $error("queues not empty after reset");

    // A waiting result that is not taken stays in place.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_lane) && $stable(o_out_byte)
        && $stable(o_last))
        else $error("waiting result changed without a transfer");

    // The result side only drains through a transfer.
    a_drain_by_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(empty) |-> $past(pop))
        else $error("result queue emptied without a transfer");

    // Every result names an existing lane.
    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ({2'b00, o_out_lane} < LANE_LIM))
        else $error("result on a lane that does not exist");

endmodule

bind ternary_rans_encoder trnenc_chk #(
    .LANES(LANES)
) u_trnenc_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .o_out_lane(o_out_lane),
    .o_out_byte(o_out_byte),
    .o_last    (o_last)
);
